// ===== rtl/sha1_pkg.sv =====
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds   = 80;
  localparam int unsigned DigWords = 5;
  localparam int unsigned RndW     = $clog2(Rounds);
  localparam int unsigned IdxW     = 3;

  localparam logic [WordW-1:0] INIT_H0 = 32'h67452301;
  localparam logic [WordW-1:0] INIT_H1 = 32'hEFCDAB89;
  localparam logic [WordW-1:0] INIT_H2 = 32'h98BADCFE;
  localparam logic [WordW-1:0] INIT_H3 = 32'h10325476;
  localparam logic [WordW-1:0] INIT_H4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic            byte_wr;
    logic            pad;
    logic            len_wr;
    logic            len_clear;
    logic            load_work;
    logic            round;
    logic [RndW-1:0] rnd;
    logic            add_chain;
    logic            restart;
    logic            out_load;
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } sha1_stat_t;

  function automatic logic [WordW-1:0] sha1_k(input logic [RndW-1:0] r);
    logic [WordW-1:0] k;
    if (r < RndW'(20))      k = 32'h5A827999;
    else if (r < RndW'(40)) k = 32'h6ED9EBA1;
    else if (r < RndW'(60)) k = 32'h8F1BBCDC;
    else                    k = 32'hCA62C1D6;
    return k;
  endfunction

endpackage

// ===== rtl/sha1_dp.sv =====
// Datapath: block words, round registers, chaining words and bit count.
module sha1_dp
  import sha1_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  sha1_cmd_t                 cmd,
  input  logic [7:0]                data_byte,
  output logic [5:0]                fill,
  output logic [DigWords*WordW-1:0] chain_flat
);

  logic [WordW-1:0] w [BlkWords];
  logic [WordW-1:0] h [DigWords];
  logic [WordW-1:0] a, b, c, d, e;
  logic [63:0]      bit_count;
  logic [WordW-1:0] f, t, w_new;

  always_comb begin
    if (cmd.rnd < RndW'(20))
      f = (b & c) | (~b & d);
    else if (cmd.rnd < RndW'(40) || cmd.rnd >= RndW'(60))
      f = b ^ c ^ d;
    else
      f = (b & c) | (b & d) | (c & d);
    t = {a[26:0], a[31:27]} + f + e + sha1_k(cmd.rnd) + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      for (int i = 0; i < BlkWords; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (fill == 6'(4 * i + j))
            w[i][8*(3-j) +: 8] <= data_byte;
        end
      end
    end else if (cmd.pad) begin
      for (int i = 0; i < BlkWords; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (fill == 6'(4 * i + j))
            w[i][8*(3-j) +: 8] <= PAD_BYTE;
          else if (fill < 6'(4 * i + j))
            w[i][8*(3-j) +: 8] <= 8'h00;
        end
      end
    end else if (cmd.len_wr) begin
      if (cmd.len_clear) begin
        for (int i = 0; i < BlkWords - 2; i++) w[i] <= '0;
      end
      w[BlkWords-2] <= bit_count[63:32];
      w[BlkWords-1] <= bit_count[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < BlkWords - 1; i++) w[i] <= w[i+1];
      w[BlkWords-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      h[0]      <= INIT_H0;
      h[1]      <= INIT_H1;
      h[2]      <= INIT_H2;
      h[3]      <= INIT_H3;
      h[4]      <= INIT_H4;
      fill      <= '0;
      bit_count <= '0;
    end else begin
      if (cmd.byte_wr) begin
        fill      <= fill + 6'd1;
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.add_chain) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DigWords; i++)
      chain_flat[WordW*(DigWords-1-i) +: WordW] = h[i];
  end

endmodule

// ===== rtl/sha1_out.sv =====
// Digest output buffer: holds five words and sends them most significant first.
module sha1_out
  import sha1_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [DigWords*WordW-1:0] digest,
  output logic                      busy,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic                      m_tlast   // last_word
);

  logic [DigWords*WordW-1:0] words;
  logic [IdxW-1:0]           idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (idx == IdxW'(DigWords - 1)) busy <= 1'b0;
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load)
      words <= digest;
    else if (busy && m_tready)
      words <= {words[(DigWords-1)*WordW-1:0], {WordW{1'b0}}};
  end

  assign m_tvalid = busy;
  assign m_tdata  = {5'b0, idx, words[DigWords*WordW-1 -: WordW]};
  assign m_tlast  = (idx == IdxW'(DigWords - 1));

endmodule

// ===== rtl/sha1_ctrl.sv =====
// Controller: request intake, padding steps, round sequencing and digest hand-off.
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       byte_valid,
  input  logic       last,
  output logic       s_tready,
  input  sha1_stat_t stat,
  output sha1_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_PAD    = 3'd4;
  localparam logic [2:0] ST_LEN    = 3'd5;
  localparam logic [2:0] ST_DIGEST = 3'd6;

  localparam logic [1:0] STG_PLAIN = 2'd0;
  localparam logic [1:0] STG_FULL  = 2'd1;
  localparam logic [1:0] STG_EXTRA = 2'd2;
  localparam logic [1:0] STG_FINAL = 2'd3;

  logic [2:0]      state, state_next;
  logic [1:0]      stage, stage_next;
  logic [RndW-1:0] rnd, rnd_next;
  logic            accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    stage_next = stage;
    rnd_next   = rnd;
    cmd        = '0;
    cmd.rnd    = rnd;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.byte_wr = byte_valid;
          if (byte_valid && stat.fill == 6'd63) begin
            stage_next = last ? STG_FULL : STG_PLAIN;
            state_next = ST_LOAD;
          end else if (last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_work = 1'b1;
        rnd_next      = '0;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + RndW'(1);
        if (rnd == RndW'(Rounds - 1)) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        unique case (stage)
          STG_PLAIN: state_next = ST_IDLE;
          STG_FULL:  state_next = ST_PAD;
          STG_EXTRA: state_next = ST_LEN;
          STG_FINAL: state_next = ST_DIGEST;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        cmd.pad = 1'b1;
        if (stat.fill[5:3] == 3'b111) begin
          stage_next = STG_EXTRA;
          state_next = ST_LOAD;
        end else begin
          stage_next = STG_PLAIN;
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.len_wr    = 1'b1;
        cmd.len_clear = (stage == STG_EXTRA);
        stage_next    = STG_FINAL;
        state_next    = ST_LOAD;
      end
      ST_DIGEST: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.restart  = 1'b1;
          stage_next   = STG_PLAIN;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= STG_PLAIN;
      rnd   <= '0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      rnd   <= rnd_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == RndW'(Rounds - 1)) |=> (state == ST_ADD))
    else $error("round loop did not end after the last round");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("digest loaded while output buffer busy");

  a_empty_req: assert property (@(posedge clk) disable iff (rst)
    (accept && !byte_valid && !last) |=> (state == ST_IDLE))
    else $error("empty request started work");

  a_pad_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD && stage == STG_FULL) |-> (stat.fill == 6'd0))
    else $error("padding after full block with nonzero fill");
`endif

endmodule

// ===== rtl/sha1_hash_engine_unit.sv =====
// Top level of the SHA-1 hash engine: byte requests in, digest words out.
//
//  channel   dir  tdata                              tuser       tlast
//  s_axis    in   data_byte[7:0]                     byte_valid  last
//  m_axis    out  digest_word[31:0], word_index[34:32]  -         last_word
//
// A request that does not complete a block stores its byte, if any; a request that fills the
// 64-byte block starts a compression in the round unit (load, 80 rounds, chain add).
// A last request adds pad and length steps plus one or two compressions, then
// hands the digest to the output buffer once it is free; the buffer sends five words.
// Reset is synchronous; the chaining words start at the standard initial values.
// s_tready is low while a block compresses, during the pad and length steps and while a digest waits for the buffer.
module sha1_hash_engine_unit
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros[39:35]
  output logic        m_tlast
);

  sha1_cmd_t                 cmd;
  sha1_stat_t                stat;
  logic [5:0]                fill;
  logic                      out_busy;
  logic [DigWords*WordW-1:0] chain_flat;

  assign stat.fill     = fill;
  assign stat.out_busy = out_busy;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .byte_valid (s_tuser),
    .last       (s_tlast),
    .s_tready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (s_tdata),
    .fill       (fill),
    .chain_flat (chain_flat)
  );

  sha1_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.out_load),
    .digest   (chain_flat),
    .busy     (out_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
